>>> hw/rtl/atsu_pkg.sv
// Shared types, constants and register map for the actuated traffic signal unit.
`default_nettype none

package atsu_pkg;

    // Number of approaches the controller supports and the lane fields carried
    localparam int APPROACHES  = 4;
    localparam int LANE_FIELDS = 4;
    localparam int LANE_MAX    = (APPROACHES < LANE_FIELDS) ? APPROACHES : LANE_FIELDS;
    localparam int LANE_MIN    = 2;

    // Field widths
    localparam int DELTA_W  = 10;
    localparam int CARS_W   = 8;
    localparam int TIMER_W  = 20;
    localparam int MS_W     = 16;
    localparam int LANE_W   = 2;
    localparam int COUNT_W  = 3;

    // Stream payload widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    // APB port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LIGHTS_ENABLE     = 3'd0;
    localparam logic [2:0] REG_APPROACHES_IN_USE = 3'd1;
    localparam logic [2:0] REG_MIN_GREEN_MS      = 3'd2;
    localparam logic [2:0] REG_MAX_GREEN_MS      = 3'd3;
    localparam logic [2:0] REG_YELLOW_MS         = 3'd4;

    // Register reset values
    localparam logic             RST_LIGHTS_ENABLE     = 1'b1;
    localparam logic [COUNT_W-1:0] RST_APPROACHES_IN_USE = 3'd4;
    localparam logic [MS_W-1:0]  RST_MIN_GREEN_MS      = 16'd5000;
    localparam logic [MS_W-1:0]  RST_MAX_GREEN_MS      = 16'd30000;
    localparam logic [MS_W-1:0]  RST_YELLOW_MS         = 16'd2000;

    typedef enum logic [1:0] {
        LIGHT_OFF    = 2'd0,
        LIGHT_RED    = 2'd1,
        LIGHT_YELLOW = 2'd2,
        LIGHT_GREEN  = 2'd3
    } light_t;

    typedef struct packed {
        logic                lights_enable;
        logic [COUNT_W-1:0]  approaches_in_use;
        logic [MS_W-1:0]     min_green_ms;
        logic [MS_W-1:0]     max_green_ms;
        logic [MS_W-1:0]     yellow_ms;
    } cfg_t;

    typedef struct packed {
        logic [LANE_FIELDS-1:0][CARS_W-1:0] cars;
        logic [DELTA_W-1:0]                 delta_ms;
    } tick_t;

    typedef struct packed {
        logic                     phase_changed;
        light_t [LANE_FIELDS-1:0] light;
        logic [LANE_W-1:0]        green_lane;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/actuated_traffic_signal_unit.sv
// Top level of the actuated traffic signal unit: APB registers, tick register and step logic.
// Flow: a tick transaction accepted into the input register moves on into the result register
// once the result register is free or draining.
// Throughput: one tick per cycle unless m_tready stalls; input and result registers move together.
// The step logic updates the phase state and the result register in the same cycle.
// Reset (rst_n low, asynchronous): green phase on approach 0, timer 0, both stages empty,
// registers back to enable 1, four approaches, 5000 ms min green, 30000 ms max green, 2000 ms yellow.
`default_nettype none

module actuated_traffic_signal_unit
    import atsu_pkg::*;
#(
    parameter int NUM_APPROACHES = APPROACHES
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // APB configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready,
    // Tick stream in
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // delta_ms[9:0], cars_lane0[17:10], cars_lane1[25:18], cars_lane2[33:26],
    // cars_lane3[41:34], zero fill [47:42]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // Result stream out
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // green_lane[1:0], light_lane0[3:2], light_lane1[5:4], light_lane2[7:6],
    // light_lane3[9:8], phase_changed[10], zero fill [15:11]
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t    cfg;
    tick_t   tick;
    logic    tick_valid;
    logic    advance;
    result_t result;

    // Move the held tick into the step logic when the result register is free or draining
    assign advance = tick_valid && (!m_tvalid || m_tready);

    atsu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    atsu_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .tick_valid (tick_valid),
        .tick       (tick)
    );

    atsu_step #(
        .NUM_APPROACHES (NUM_APPROACHES)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tick      (tick),
        .fire      (advance),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .result    (result)
    );

    // Pack the result from the low bits up
    always_comb
    begin
        m_tdata         = '0;
        m_tdata[1:0]    = result.green_lane;
        for (int i = 0; i < LANE_FIELDS; i++)
        begin
            m_tdata[LANE_W + 2*i +: 2] = result.light[i];
        end
        m_tdata[LANE_W + 2*LANE_FIELDS] = result.phase_changed;
    end

endmodule

`default_nettype wire

>>> hw/rtl/atsu_cfg.sv
// APB register file holding the controller's configuration.
`default_nettype none

module atsu_cfg
    import atsu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lights_enable     <= RST_LIGHTS_ENABLE;
            cfg_reg.approaches_in_use <= RST_APPROACHES_IN_USE;
            cfg_reg.min_green_ms      <= RST_MIN_GREEN_MS;
            cfg_reg.max_green_ms      <= RST_MAX_GREEN_MS;
            cfg_reg.yellow_ms         <= RST_YELLOW_MS;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_LIGHTS_ENABLE:     cfg_reg.lights_enable     <= pwdata[0];
                REG_APPROACHES_IN_USE: cfg_reg.approaches_in_use <= pwdata[COUNT_W-1:0];
                REG_MIN_GREEN_MS:      cfg_reg.min_green_ms      <= pwdata[MS_W-1:0];
                REG_MAX_GREEN_MS:      cfg_reg.max_green_ms      <= pwdata[MS_W-1:0];
                REG_YELLOW_MS:         cfg_reg.yellow_ms         <= pwdata[MS_W-1:0];
                default:               ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        case (reg_index)
            REG_LIGHTS_ENABLE:     prdata[0]           = cfg_reg.lights_enable;
            REG_APPROACHES_IN_USE: prdata[COUNT_W-1:0] = cfg_reg.approaches_in_use;
            REG_MIN_GREEN_MS:      prdata[MS_W-1:0]    = cfg_reg.min_green_ms;
            REG_MAX_GREEN_MS:      prdata[MS_W-1:0]    = cfg_reg.max_green_ms;
            REG_YELLOW_MS:         prdata[MS_W-1:0]    = cfg_reg.yellow_ms;
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/atsu_in_reg.sv
// Input register: captures one tick transaction and holds it until the step logic takes it.
`default_nettype none

module atsu_in_reg
    import atsu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic                  advance,
    output logic                       tick_valid,
    output tick_t                      tick
);

    logic  valid_reg;
    logic  valid_next;
    tick_t tick_reg;
    logic  load;

    // Take a new tick whenever the register is empty or is being drained
    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load || (valid_reg && !advance);
    assign tick_valid = valid_reg;
    assign tick       = tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Unpack the fields from the low bits up
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tick_reg.delta_ms <= s_tdata[DELTA_W-1:0];
            for (int i = 0; i < LANE_FIELDS; i++)
            begin
                tick_reg.cars[i] <= s_tdata[DELTA_W + i*CARS_W +: CARS_W];
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/atsu_step.sv
// Per-tick controller logic: phase state, timer, next-green choice and the result register.
`default_nettype none

module atsu_step
    import atsu_pkg::*;
#(
    parameter int NUM_APPROACHES = APPROACHES
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire tick_t tick,
    input  wire logic  fire,
    input  wire logic  out_ready,
    output logic       out_valid,
    output result_t    result
);

    // Approach count is capped by the parameter and by the lane fields carried
    localparam int LANE_CAP = (NUM_APPROACHES < LANE_FIELDS) ? NUM_APPROACHES : LANE_FIELDS;

    logic                   phase_yellow_reg;
    logic                   phase_yellow_next;
    logic [LANE_W-1:0]      active_lane_reg;
    logic [LANE_W-1:0]      active_lane_next;
    logic [TIMER_W-1:0]     phase_timer_reg;
    logic [TIMER_W-1:0]     phase_timer_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                result_reg;
    result_t                result_next;

    logic [COUNT_W-1:0]                 lanes_n;
    logic [LANE_FIELDS-1:0]             lane_used;
    logic [LANE_FIELDS-1:0][CARS_W-1:0] cars;
    logic [TIMER_W:0]                   timer_sum;
    logic [TIMER_W-1:0]                 timer_sat;
    logic                               found;
    logic [LANE_W-1:0]                  best_lane;
    logic [CARS_W-1:0]                  best_cars;
    logic                               other_waiting;
    logic [CARS_W-1:0]                  on_green;
    logic                               go_yellow;
    logic                               yellow_done;
    logic                               changed;

    // Clamp the approach count to the supported range
    always_comb
    begin
        if (cfg.approaches_in_use < COUNT_W'(LANE_MIN))
            lanes_n = COUNT_W'(LANE_MIN);
        else if (cfg.approaches_in_use > COUNT_W'(LANE_CAP))
            lanes_n = COUNT_W'(LANE_CAP);
        else
            lanes_n = cfg.approaches_in_use;
    end

    // Mask counts of lanes without signal heads
    always_comb
    begin
        for (int i = 0; i < LANE_FIELDS; i++)
        begin
            lane_used[i] = (COUNT_W'(i) < lanes_n);
            cars[i]      = lane_used[i] ? tick.cars[i] : '0;
        end
    end

    // Advance the saturating phase timer
    assign timer_sum = {1'b0, phase_timer_reg} + (TIMER_W+1)'(tick.delta_ms);
    assign timer_sat = timer_sum[TIMER_W] ? {TIMER_W{1'b1}} : timer_sum[TIMER_W-1:0];

    // Find the busiest other lane in use, lowest index wins ties
    always_comb
    begin
        found         = 1'b0;
        best_lane     = '0;
        best_cars     = '0;
        other_waiting = 1'b0;
        for (int i = 0; i < LANE_FIELDS; i++)
        begin
            if (lane_used[i] && (LANE_W'(i) != active_lane_reg))
            begin
                if (!found || (cars[i] > best_cars))
                begin
                    found     = 1'b1;
                    best_lane = LANE_W'(i);
                    best_cars = cars[i];
                end
                if (cars[i] != '0)
                    other_waiting = 1'b1;
            end
        end
    end

    assign on_green    = cars[active_lane_reg];
    assign go_yellow   = other_waiting &&
                         (((on_green == '0) && (timer_sat > TIMER_W'(cfg.min_green_ms))) ||
                          (timer_sat > TIMER_W'(cfg.max_green_ms)));
    assign yellow_done = (timer_sat >= TIMER_W'(cfg.yellow_ms));

    // Next phase state
    always_comb
    begin
        phase_yellow_next = phase_yellow_reg;
        active_lane_next  = active_lane_reg;
        phase_timer_next  = phase_timer_reg;
        changed           = 1'b0;
        if (cfg.lights_enable)
        begin
            phase_timer_next = timer_sat;
            if (phase_yellow_reg)
            begin
                if (yellow_done)
                begin
                    active_lane_next  = best_lane;
                    phase_yellow_next = 1'b0;
                    phase_timer_next  = '0;
                    changed           = 1'b1;
                end
            end
            else if (go_yellow)
            begin
                phase_yellow_next = 1'b1;
                phase_timer_next  = '0;
                changed           = 1'b1;
            end
        end
    end

    // Build the light pattern from the updated state
    always_comb
    begin
        result_next.green_lane    = active_lane_next;
        result_next.phase_changed = changed;
        for (int i = 0; i < LANE_FIELDS; i++)
        begin
            if (!cfg.lights_enable || !lane_used[i])
                result_next.light[i] = LIGHT_OFF;
            else if (LANE_W'(i) == active_lane_next)
                result_next.light[i] = phase_yellow_next ? LIGHT_YELLOW : LIGHT_GREEN;
            else
                result_next.light[i] = LIGHT_RED;
        end
    end

    // Hold a result until it is taken
    assign out_valid_next = fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_yellow_reg <= 1'b0;
            active_lane_reg  <= '0;
            phase_timer_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_yellow_reg <= phase_yellow_next;
                active_lane_reg  <= active_lane_next;
                phase_timer_reg  <= phase_timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/atsu_checker.sv
// Port-level checks for the actuated traffic signal unit, bound to the top level.
`default_nettype none

module atsu_checker
    import atsu_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // At most one approach shows green or yellow
    a_one_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($countones({m_tdata[9], m_tdata[7], m_tdata[5], m_tdata[3]}) <= 1))
        else $error("more than one approach holds green or yellow");

    // With all lights off no phase change is reported
    a_off_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[9:2] == 8'h00) |-> !m_tdata[10])
        else $error("phase change reported while lights are off");

    // An accepted tick yields a result while the receiver stays ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted tick produced no result");

endmodule

bind actuated_traffic_signal_unit atsu_checker u_atsu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready)
);

`default_nettype wire

>>> tb/actuated_traffic_signal_unit_test.sv
// Self-checking stream and register testbench for the actuated traffic signal unit.
`timescale 1ns / 1ps

module actuated_traffic_signal_unit_test
    import atsu_pkg::*;
;

    localparam int STALL_LIMIT  = 5000;
    localparam int SEG_COUNT    = 7;
    localparam int SEG_TICKS    = 40;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [15:0] value;
        tick_t       tick;
        logic        pinned;
        result_t     res;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    // delta_ms[9:0], cars_lane0[17:10], cars_lane1[25:18], cars_lane2[33:26],
    // cars_lane3[41:34], zero fill [47:42]
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // green_lane[1:0], light_lane0[3:2], light_lane1[5:4], light_lane2[7:6],
    // light_lane3[9:8], phase_changed[10], zero fill [15:11]
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Directed row whose result is typed in rather than predicted
    logic    pin_valid;
    result_t pin_res;

    // Register copy and controller state of the predictor
    logic               run_enable  = RST_LIGHTS_ENABLE;
    logic [COUNT_W-1:0] lanes_cfg   = RST_APPROACHES_IN_USE;
    logic [MS_W-1:0]    min_green   = RST_MIN_GREEN_MS;
    logic [MS_W-1:0]    max_green   = RST_MAX_GREEN_MS;
    logic [MS_W-1:0]    yellow_len  = RST_YELLOW_MS;
    logic               yellow_now  = 1'b0;
    logic [LANE_W-1:0]  lane_now    = '0;
    logic [TIMER_W-1:0] phase_ms    = '0;

    result_t   pending_lights[$];
    result_t   predicted;
    plan_row_t plan[$];

    int src_idle;
    int sink_idle;
    int mismatches       = 0;
    int ticks_sent       = 0;
    int results_checked  = 0;
    int phase_changes    = 0;
    int settings_applied = 0;
    int stall_cycles     = 0;

    actuated_traffic_signal_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the controller by one tick and return the lights it shows
    function automatic result_t predict_tick(input tick_t t);
        int          n;
        int          i;
        int          cars[LANE_FIELDS];
        int          on_green;
        int          max_other;
        int          best;
        int          best_cars;
        logic        found;
        logic [20:0] sum;
        result_t     r;

        n = int'(lanes_cfg);
        if (n < LANE_MIN)
            n = LANE_MIN;
        if (n > LANE_MAX)
            n = LANE_MAX;
        for (i = 0; i < LANE_FIELDS; i++)
            cars[i] = (i < n) ? int'(t.cars[i]) : 0;
        r.phase_changed = 1'b0;

        if (run_enable)
        begin
            sum = {1'b0, phase_ms} + 21'(t.delta_ms);
            phase_ms = sum[20] ? '1 : sum[19:0];
            if (yellow_now)
            begin
                // Yellow expiry: busiest other lane wins, lowest index on a tie
                if (phase_ms >= yellow_len)
                begin
                    found = 1'b0;
                    best = 0;
                    best_cars = 0;
                    for (i = 0; i < n; i++)
                    begin
                        if (i != lane_now && (!found || cars[i] > best_cars))
                        begin
                            found = 1'b1;
                            best = i;
                            best_cars = cars[i];
                        end
                    end
                    lane_now = best[LANE_W-1:0];
                    yellow_now = 1'b0;
                    phase_ms = '0;
                    r.phase_changed = 1'b1;
                end
            end
            else
            begin
                // Green: leave only when another lane in use has a car waiting
                on_green = (lane_now < n) ? cars[lane_now] : 0;
                max_other = 0;
                for (i = 0; i < n; i++)
                    if (i != lane_now && cars[i] > max_other)
                        max_other = cars[i];
                if (max_other > 0 && ((on_green == 0 && phase_ms > min_green) ||
                                      phase_ms > max_green))
                begin
                    yellow_now = 1'b1;
                    phase_ms = '0;
                    r.phase_changed = 1'b1;
                end
            end
        end

        r.green_lane = lane_now;
        for (i = 0; i < LANE_FIELDS; i++)
        begin
            r.light[i] = LIGHT_OFF;
            if (run_enable && i < n)
            begin
                if (i == lane_now)
                    r.light[i] = yellow_now ? LIGHT_YELLOW : LIGHT_GREEN;
                else
                    r.light[i] = LIGHT_RED;
            end
        end
        return r;
    endfunction

    function automatic result_t lights_of(input int lane, input light_t l0, input light_t l1,
                                          input light_t l2, input light_t l3, input logic chg);
        result_t r;

        r.green_lane    = lane[LANE_W-1:0];
        r.light[0]      = l0;
        r.light[1]      = l1;
        r.light[2]      = l2;
        r.light[3]      = l3;
        r.phase_changed = chg;
        return r;
    endfunction

    function automatic tick_t make_tick(input int d, input int c0, input int c1,
                                        input int c2, input int c3);
        tick_t t;

        t.delta_ms = d[DELTA_W-1:0];
        t.cars[0]  = c0[CARS_W-1:0];
        t.cars[1]  = c1[CARS_W-1:0];
        t.cars[2]  = c2[CARS_W-1:0];
        t.cars[3]  = c3[CARS_W-1:0];
        return t;
    endfunction

    // Empty or lightly loaded lanes half the time, random counts otherwise, with full lanes and extreme deltas mixed in
    function automatic tick_t random_tick();
        tick_t t;
        int    i;
        int    pick;

        pick = $urandom_range(9);
        if (pick == 0)
            t.delta_ms = '0;
        else if (pick == 1)
            t.delta_ms = '1;
        else
            t.delta_ms = DELTA_W'($urandom_range(1023));
        for (i = 0; i < LANE_FIELDS; i++)
        begin
            pick = $urandom_range(9);
            if (pick < 4)
                t.cars[i] = '0;
            else if (pick == 4)
                t.cars[i] = '1;
            else if (pick == 5)
                t.cars[i] = CARS_W'($urandom_range(3, 1));
            else
                t.cars[i] = CARS_W'($urandom_range(255));
        end
        return t;
    endfunction

    // Short times keep the phases turning over; extremes and full range now and then
    function automatic int pick_ms();
        int pick;

        pick = $urandom_range(7);
        if (pick == 0)
            return 0;
        else if (pick == 1)
            return 65535;
        else if (pick < 6)
            return $urandom_range(4000);
        else
            return $urandom_range(65535);
    endfunction

    task automatic add_tick(input int d, input int c0, input int c1, input int c2, input int c3,
                            input logic pinned, input result_t res);
        plan_row_t row;

        row = '0;
        row.kind   = ROW_TICK;
        row.tick   = make_tick(d, c0, c1, c2, c3);
        row.pinned = pinned;
        row.res    = res;
        plan.insert(plan.size(), row);
    endtask

    task automatic add_write(input logic [2:0] idx, input int value);
        plan_row_t row;

        row = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = value[15:0];
        plan.insert(plan.size(), row);
    endtask

    // Offer one tick, with random sender gaps, and hold it until accepted
    task automatic push_tick(input tick_t t, input logic pinned, input result_t res);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_TDATA_W'({$urandom, $urandom});
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {{(IN_TDATA_W - $bits(tick_t)){1'b0}}, t};
        pin_valid <= pinned;
        pin_res   <= res;
        do
            @(posedge clk);
        while (!s_tready);
        ticks_sent++;
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_lights.size() != 0);
    endtask

    // Setup and access cycles; psel stays up so writes can run back to back
    task automatic apb_write(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_LIGHTS_ENABLE:     run_enable = value[0];
            REG_APPROACHES_IN_USE: lanes_cfg  = value[COUNT_W-1:0];
            REG_MIN_GREEN_MS:      min_green  = value;
            REG_MAX_GREEN_MS:      max_green  = value;
            REG_YELLOW_MS:         yellow_len = value;
            default: ;
        endcase
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic enable, input int count, input int min_ms,
                                  input int max_ms, input int yel_ms);
        wait_drained();
        apb_write(REG_LIGHTS_ENABLE, {15'd0, enable});
        apb_write(REG_APPROACHES_IN_USE, count[15:0]);
        apb_write(REG_MIN_GREEN_MS, min_ms[15:0]);
        apb_write(REG_MAX_GREEN_MS, max_ms[15:0]);
        apb_write(REG_YELLOW_MS, yel_ms[15:0]);
        apb_release();
        settings_applied++;
    endtask

    task automatic compare_lights(input result_t exp, input result_t got);
        int i;

        if (got.green_lane !== exp.green_lane)
        begin
            mismatches++;
            $display("%0t: green_lane expected %0d got %0d", $time,
                     exp.green_lane, got.green_lane);
        end
        for (i = 0; i < LANE_FIELDS; i++)
        begin
            if (got.light[i] !== exp.light[i])
            begin
                mismatches++;
                $display("%0t: light_lane%0d expected %0d got %0d", $time, i,
                         exp.light[i], got.light[i]);
            end
        end
        if (got.phase_changed !== exp.phase_changed)
        begin
            mismatches++;
            $display("%0t: phase_changed expected %0d got %0d", $time,
                     exp.phase_changed, got.phase_changed);
        end
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle);

    // Check results against the oldest expectation, then predict newly accepted ticks
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (m_tdata[10])
                    phase_changes++;
                if (pending_lights.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no tick outstanding: expected none got %h",
                             $time, m_tdata);
                end
                else
                    compare_lights(pending_lights.pop_front(),
                                   result_t'(m_tdata[$bits(result_t)-1:0]));
            end
            if (s_tvalid && s_tready)
            begin
                predicted = predict_tick(tick_t'(s_tdata[$bits(tick_t)-1:0]));
                pending_lights.insert(pending_lights.size(), pin_valid ? pin_res : predicted);
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int    ph;
        int    seg;
        int    k;

        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        pin_valid <= 1'b0;
        pin_res   <= '0;
        src_idle  = 15;
        sink_idle = 78;

        // Directed plan: reset state, field extremes, zero timings, clamped lane counts,
        // inactive green lane, ties, empty yellow expiry, disable, timing boundaries
        add_tick(0, 0, 0, 0, 0, 1'b1,
                 lights_of(0, LIGHT_GREEN, LIGHT_RED, LIGHT_RED, LIGHT_RED, 1'b0));
        add_tick(1023, 255, 255, 255, 255, 1'b1,
                 lights_of(0, LIGHT_GREEN, LIGHT_RED, LIGHT_RED, LIGHT_RED, 1'b0));
        add_write(REG_MIN_GREEN_MS, 0);
        add_write(REG_MAX_GREEN_MS, 0);
        add_write(REG_YELLOW_MS, 0);
        add_tick(0, 0, 0, 0, 1, 1'b1,
                 lights_of(0, LIGHT_YELLOW, LIGHT_RED, LIGHT_RED, LIGHT_RED, 1'b1));
        add_tick(0, 0, 0, 0, 0, 1'b1,
                 lights_of(1, LIGHT_RED, LIGHT_GREEN, LIGHT_RED, LIGHT_RED, 1'b1));
        add_tick(1, 0, 5, 0, 0, 1'b1,
                 lights_of(1, LIGHT_RED, LIGHT_GREEN, LIGHT_RED, LIGHT_RED, 1'b0));
        add_tick(1, 0, 5, 3, 0, 1'b1,
                 lights_of(1, LIGHT_RED, LIGHT_YELLOW, LIGHT_RED, LIGHT_RED, 1'b1));
        add_tick(0, 7, 255, 7, 9, 1'b1,
                 lights_of(3, LIGHT_RED, LIGHT_RED, LIGHT_RED, LIGHT_GREEN, 1'b1));
        add_write(REG_APPROACHES_IN_USE, 0);
        add_tick(0, 0, 0, 0, 0, 1'b1,
                 lights_of(3, LIGHT_RED, LIGHT_RED, LIGHT_OFF, LIGHT_OFF, 1'b0));
        add_tick(5, 0, 4, 200, 200, 1'b1,
                 lights_of(3, LIGHT_RED, LIGHT_RED, LIGHT_OFF, LIGHT_OFF, 1'b1));
        add_tick(0, 6, 6, 0, 0, 1'b1,
                 lights_of(0, LIGHT_GREEN, LIGHT_RED, LIGHT_OFF, LIGHT_OFF, 1'b1));
        add_write(REG_APPROACHES_IN_USE, 7);
        add_tick(0, 1, 0, 0, 0, 1'b1,
                 lights_of(0, LIGHT_GREEN, LIGHT_RED, LIGHT_RED, LIGHT_RED, 1'b0));
        add_write(REG_APPROACHES_IN_USE, 3);
        add_write(REG_LIGHTS_ENABLE, 0);
        add_tick(1023, 255, 255, 255, 255, 1'b1,
                 lights_of(0, LIGHT_OFF, LIGHT_OFF, LIGHT_OFF, LIGHT_OFF, 1'b0));
        add_write(REG_LIGHTS_ENABLE, 1);
        add_write(REG_MIN_GREEN_MS, 10);
        add_write(REG_MAX_GREEN_MS, 65535);
        add_write(REG_YELLOW_MS, 3);
        add_tick(10, 0, 0, 1, 0, 1'b1,
                 lights_of(0, LIGHT_GREEN, LIGHT_RED, LIGHT_RED, LIGHT_OFF, 1'b0));
        add_tick(1, 0, 0, 1, 0, 1'b1,
                 lights_of(0, LIGHT_YELLOW, LIGHT_RED, LIGHT_RED, LIGHT_OFF, 1'b1));
        add_tick(2, 0, 2, 0, 0, 1'b0, '0);
        add_tick(1, 0, 2, 0, 9, 1'b0, '0);
        add_write(REG_APPROACHES_IN_USE, 1);
        add_tick(0, 255, 255, 255, 255, 1'b0, '0);

        // Hold reset, then release
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < 3; ph++)
        begin
            // Sender idles lightly, then receiver lightly, then nobody idles
            src_idle  = (ph == 0) ? 15 : (ph == 1) ? 78 : 0;
            sink_idle = (ph == 0) ? 78 : (ph == 1) ? 15 : 0;

            if (ph == 0)
            begin
                for (k = 0; k < plan.size(); k++)
                begin
                    if (plan[k].kind == ROW_WRITE)
                    begin
                        wait_drained();
                        apb_write(plan[k].reg_idx, plan[k].value);
                        apb_release();
                    end
                    else
                        push_tick(plan[k].tick, plan[k].pinned, plan[k].res);
                end
            end

            for (seg = 0; seg < SEG_COUNT; seg++)
            begin
                apply_settings($urandom_range(9) != 0, $urandom_range(7),
                               pick_ms(), pick_ms(), pick_ms());
                repeat (SEG_TICKS) push_tick(random_tick(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d ticks over %0d register settings plus directed writes;",
                 ticks_sent, settings_applied);
        $display("checked %0d results with %0d phase changes under three stall mixes.",
                 results_checked, phase_changes);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
